/* sv/xtea_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register codes and the XTEA mix function.
// Used by xtea_round, xtea_block_cipher, xtea_chk and the testbench; no dependencies.
package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

  // Round counter width; covers any MAX_ROUNDS up to 255.
  localparam int LEFT_W = 8;
  typedef logic [LEFT_W-1:0] left_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 3'd5;

  localparam logic [6:0] ROUNDS_RESET = 7'd32;

  typedef logic [3:0][31:0] key_t;

  // One block in flight: direction, data words, running sum, rounds still to apply.
  typedef struct packed {
    logic        dec;
    left_t       left;
    logic [31:0] sum;
    logic [31:0] v0;
    logic [31:0] v1;
  } lane_t;

  function automatic logic [31:0] mix(input logic [31:0] x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

/* sv/xtea_round.sv */
`timescale 1ns / 1ps
// One full XTEA cycle as two register stages, one half-round per stage.
// Depends on xtea_pkg.
module xtea_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  xtea_pkg::lane_t      in_lane,
  input  xtea_pkg::key_t       key,
  output logic                 out_valid,
  output xtea_pkg::lane_t      out_lane
);

  xtea_pkg::lane_t half_next;
  xtea_pkg::lane_t half;
  logic            half_valid;
  xtea_pkg::lane_t lane_next;

  logic [31:0] mix_a;
  logic [31:0] mix_b;

  // First half: enc updates v0 and steps sum up; dec updates v1 and steps sum down.
  always_comb begin
    half_next = in_lane;
    mix_a     = '0;
    if (in_lane.left != '0) begin
      if (!in_lane.dec) begin
        mix_a = xtea_pkg::mix(in_lane.v1) ^ (in_lane.sum + key[in_lane.sum[1:0]]);
        half_next.v0  = in_lane.v0 + mix_a;
        half_next.sum = in_lane.sum + xtea_pkg::XTEA_DELTA;
      end else begin
        mix_a = xtea_pkg::mix(in_lane.v0) ^ (in_lane.sum + key[in_lane.sum[12:11]]);
        half_next.v1  = in_lane.v1 - mix_a;
        half_next.sum = in_lane.sum - xtea_pkg::XTEA_DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
    end else begin
      half_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    half <= half_next;
  end

  // Second half finishes the cycle and counts it off.
  always_comb begin
    lane_next = half;
    mix_b     = '0;
    if (half.left != '0) begin
      if (!half.dec) begin
        mix_b = xtea_pkg::mix(half.v0) ^ (half.sum + key[half.sum[12:11]]);
        lane_next.v1 = half.v1 + mix_b;
      end else begin
        mix_b = xtea_pkg::mix(half.v1) ^ (half.sum + key[half.sum[1:0]]);
        lane_next.v0 = half.v0 - mix_b;
      end
      lane_next.left = half.left - xtea_pkg::left_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= half_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule

/* sv/xtea_block_cipher.sv */
`timescale 1ns / 1ps
// XTEA cipher pipeline: one block accepted every cycle, busy only during reset.
// Pipeline: one entry stage, then two half-round stages per XTEA cycle, all cycles always
// traversed whatever the round setting. The receiver cannot stall, so nothing ever backs up.
// Synchronous reset clears valid bits and loads register defaults (32 rounds, encrypt).
// Depends on xtea_pkg and xtea_round.
module xtea_block_cipher #(
  parameter int MAX_ROUNDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     block_first_word,
  input  logic [31:0]                     block_second_word,
  output logic                            result_valid,
  output logic [31:0]                     result_first_word,
  output logic [31:0]                     result_second_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  xtea_pkg::key_t  key;
  logic [6:0]      round_count;
  logic            decrypt_mode;

  xtea_pkg::left_t rounds_sat;
  xtea_pkg::lane_t entry_next;
  logic            entry_valid;
  xtea_pkg::lane_t entry_lane;

  logic            stage_valid [MAX_ROUNDS+1];
  xtea_pkg::lane_t stage_lane  [MAX_ROUNDS+1];

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      round_count  <= xtea_pkg::ROUNDS_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xtea_pkg::REG_KEY0:    key[0]       <= cfg_data;
        xtea_pkg::REG_KEY1:    key[1]       <= cfg_data;
        xtea_pkg::REG_KEY2:    key[2]       <= cfg_data;
        xtea_pkg::REG_KEY3:    key[3]       <= cfg_data;
        xtea_pkg::REG_ROUNDS:  round_count  <= cfg_data[6:0];
        xtea_pkg::REG_DECRYPT: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(round_count) > MAX_ROUNDS) begin
      rounds_sat = xtea_pkg::left_t'(MAX_ROUNDS);
    end else begin
      rounds_sat = xtea_pkg::left_t'(round_count);
    end
    entry_next.dec  = decrypt_mode;
    entry_next.left = rounds_sat;
    entry_next.v0   = block_first_word;
    entry_next.v1   = block_second_word;
    // decrypt starts from DELTA * rounds (mod 2^32)
    if (decrypt_mode) begin
      entry_next.sum = xtea_pkg::XTEA_DELTA * {{(32-xtea_pkg::LEFT_W){1'b0}}, rounds_sat};
    end else begin
      entry_next.sum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else begin
      entry_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    entry_lane <= entry_next;
  end

  assign stage_valid[0] = entry_valid;
  assign stage_lane[0]  = entry_lane;

  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
    xtea_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r]),
      .in_lane   (stage_lane[r]),
      .key       (key),
      .out_valid (stage_valid[r+1]),
      .out_lane  (stage_lane[r+1])
    );
  end

  assign result_valid       = stage_valid[MAX_ROUNDS];
  assign result_first_word  = stage_lane[MAX_ROUNDS].v0;
  assign result_second_word = stage_lane[MAX_ROUNDS].v1;

endmodule

/* sv/xtea_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for xtea_block_cipher, attached by bind.
// Depends on xtea_pkg for register codes.
module xtea_chk #(
  parameter int MAX_ROUNDS = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [31:0]                     block_first_word,
  input logic [31:0]                     block_second_word,
  input logic                            result_valid,
  input logic [31:0]                     result_first_word,
  input logic [31:0]                     result_second_word,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [31:0]                     cfg_data
);

  localparam int LAT   = 2 * MAX_ROUNDS + 1;
  localparam int WARMW = $clog2(LAT + 1);

  logic [WARMW-1:0] warm_cnt;
  logic             warm;
  logic [6:0]       rounds_shadow;

  assign warm = (int'(warm_cnt) >= LAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_cnt <= '0;
    end else if (!warm) begin
      warm_cnt <= warm_cnt + WARMW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds_shadow <= xtea_pkg::ROUNDS_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == xtea_pkg::REG_ROUNDS) begin
      rounds_shadow <= cfg_data[6:0];
    end
  end

  // every accepted block yields exactly one result, after a fixed latency
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    warm |-> (result_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match accepted block");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe after reset");

  a_no_accept_in_reset: assert property (@(posedge clk)
    rst |-> (busy && !cfg_ready))
    else $error("transfer possible during reset");

  // zero rounds passes the block through unchanged
  a_zero_pass: assert property (@(posedge clk) disable iff (rst)
    (warm && rounds_shadow == 7'd0 && result_valid) |->
      (result_first_word == $past(block_first_word, LAT) &&
       result_second_word == $past(block_second_word, LAT)))
    else $error("zero-round block altered");

endmodule

bind xtea_block_cipher xtea_chk #(.MAX_ROUNDS(MAX_ROUNDS)) u_xtea_chk (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for xtea_block_cipher: directed and random blocks under
// several key/round/direction settings, each result checked against a local XTEA model.
// Depends on xtea_pkg and the xtea_block_cipher RTL.
module testbench;

  localparam int MAX_ROUNDS = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BLOCKS = 143;
  // Indexes past the register list; writes there must be ignored.
  localparam logic [xtea_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [xtea_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    bit [31:0] first;
    bit [31:0] second;
  } block_words_t;

  localparam bit [31:0] EDGE_WORDS [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h4142_4344};
  localparam int ROUND_PICKS [RANDOM_PHASES] = '{64, 1, 0, 127, 65, 32, 2, 63, -1, -1};
  localparam int IDLE_MIX [3] = '{0, 74, 38};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] block_first_word = '0;
  logic [31:0] block_second_word = '0;
  logic result_valid;
  logic [31:0] result_first_word;
  logic [31:0] result_second_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow of the block's registers, updated on each config transfer.
  bit [31:0] key_shadow [4];
  bit [6:0] rounds_shadow;
  bit decrypt_shadow;

  block_words_t block_in_q [$];
  block_words_t cipher_out_q [$];
  block_words_t arrived;
  block_words_t want;

  int send_idle_pct = 0;
  bit took_item = 1'b0;
  bit link_active = 1'b0;
  int stall_cycles = 0;
  int fail_count = 0;
  int blocks_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int settings_used = 0;

  xtea_block_cipher #(.MAX_ROUNDS(MAX_ROUNDS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block_first_word(block_first_word),
    .block_second_word(block_second_word),
    .result_valid(result_valid),
    .result_first_word(result_first_word),
    .result_second_word(result_second_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit [31:0] feistel_mix(bit [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic block_words_t xtea_cipher(block_words_t blk);
    bit [31:0] y;
    bit [31:0] z;
    bit [31:0] sum;
    bit [31:0] n;
    block_words_t res;
    y = blk.first;
    z = blk.second;
    n = (rounds_shadow > MAX_ROUNDS) ? MAX_ROUNDS : rounds_shadow;
    if (!decrypt_shadow) begin
      sum = '0;
      repeat (n) begin
        y = y + (feistel_mix(z) ^ (sum + key_shadow[sum[1:0]]));
        sum = sum + xtea_pkg::XTEA_DELTA;
        z = z + (feistel_mix(y) ^ (sum + key_shadow[sum[12:11]]));
      end
    end else begin
      sum = xtea_pkg::XTEA_DELTA * n;
      repeat (n) begin
        z = z - (feistel_mix(y) ^ (sum + key_shadow[sum[12:11]]));
        sum = sum - xtea_pkg::XTEA_DELTA;
        y = y - (feistel_mix(z) ^ (sum + key_shadow[sum[1:0]]));
      end
    end
    res.first = y;
    res.second = z;
    return res;
  endfunction

  function automatic bit [31:0] rand_word();
    int k;
    k = $urandom_range(31);
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << k;
      3: return ~(32'h1 << k);
      default: return $urandom;
    endcase
  endfunction

  // Monitor: config shadow, result checks, accepted blocks.
  always @(posedge clk) begin
    took_item = 1'b0;
    link_active = 1'b0;
    if (rst) begin
      key_shadow = '{default: 32'h0};
      rounds_shadow = xtea_pkg::ROUNDS_RESET;
      decrypt_shadow = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        link_active = 1'b1;
        cfg_writes++;
        case (cfg_index)
          xtea_pkg::REG_KEY0, xtea_pkg::REG_KEY1, xtea_pkg::REG_KEY2, xtea_pkg::REG_KEY3:
            key_shadow[cfg_index[1:0]] = cfg_data;
          xtea_pkg::REG_ROUNDS: rounds_shadow = cfg_data[6:0];
          xtea_pkg::REG_DECRYPT: decrypt_shadow = cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid) begin
        link_active = 1'b1;
        if (cipher_out_q.size() == 0) begin
          $error("result with nothing pending: %h %h", result_first_word, result_second_word);
          fail_count++;
        end else begin
          want = cipher_out_q.pop_front();
          results_checked++;
          if (result_first_word !== want.first) begin
            $error("result_first_word: expected %h, actual %h", want.first, result_first_word);
            fail_count++;
          end
          if (result_second_word !== want.second) begin
            $error("result_second_word: expected %h, actual %h", want.second,
                   result_second_word);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        took_item = 1'b1;
        link_active = 1'b1;
        blocks_sent++;
        arrived.first = block_first_word;
        arrived.second = block_second_word;
        cipher_out_q.push_back(xtea_cipher(arrived));
      end
    end
  end

  // Driver: an offered block stays up until its transfer, otherwise random gaps.
  always @(negedge clk) begin
    if (took_item) block_in_q.delete(0);
    if (block_in_q.size() != 0 &&
        ((start && !took_item) || $urandom_range(99) >= send_idle_pct)) begin
      start <= 1'b1;
      block_first_word <= block_in_q[0].first;
      block_second_word <= block_in_q[0].second;
    end else begin
      start <= 1'b0;
    end
  end

  always @(negedge clk) begin
    stall_cycles = link_active ? 0 : stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // High bits of the narrow registers carry junk; the block must drop them.
  task automatic set_cipher(input bit [31:0] k0, input bit [31:0] k1, input bit [31:0] k2,
                            input bit [31:0] k3, input bit [6:0] rounds, input bit dec);
    bit [31:0] junk;
    junk = $urandom;
    write_reg(xtea_pkg::REG_KEY0, k0);
    write_reg(xtea_pkg::REG_KEY1, k1);
    write_reg(xtea_pkg::REG_KEY2, k2);
    write_reg(xtea_pkg::REG_KEY3, k3);
    write_reg(xtea_pkg::REG_ROUNDS, {junk[31:7], rounds});
    write_reg(xtea_pkg::REG_DECRYPT, {junk[31:1], dec});
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_blocks(input int count, input bit edge_set, input int idle_pct);
    block_words_t blk;
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (edge_set) begin
        blk.first = EDGE_WORDS[i % 8];
        blk.second = EDGE_WORDS[(i * 3 + 1) % 8];
      end else begin
        blk.first = rand_word();
        blk.second = rand_word();
      end
      block_in_q.push_back(blk);
    end
    wait (block_in_q.size() == 0 && cipher_out_q.size() == 0);
  endtask

  initial begin
    bit [6:0] rounds;
    bit [31:0] k [4];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero key, 32 rounds, encrypt.
    run_blocks(5, 1'b1, 0);
    set_cipher(32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C, 7'd32, 1'b0);
    run_blocks(4, 1'b1, 0);
    set_cipher(32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C, 7'd32, 1'b1);
    run_blocks(4, 1'b1, 38);
    // Zero rounds passes the block through; 127 saturates to the maximum.
    set_cipher($urandom, $urandom, $urandom, $urandom, 7'd0, 1'b0);
    run_blocks(3, 1'b1, 0);
    set_cipher($urandom, $urandom, $urandom, $urandom, 7'd127, 1'b1);
    run_blocks(3, 1'b1, 74);
    set_cipher(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64, 1'b0);
    run_blocks(3, 1'b1, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (k[j]) k[j] = (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : rand_word();
      rounds = (ROUND_PICKS[p] < 0) ? 7'($urandom_range(127)) : 7'(ROUND_PICKS[p]);
      set_cipher(k[0], k[1], k[2], k[3], rounds, p[0]);
      run_blocks(PHASE_BLOCKS / 2, 1'b0, IDLE_MIX[p % 3]);
      run_blocks(PHASE_BLOCKS - PHASE_BLOCKS / 2, 1'b0, IDLE_MIX[(p + 1) % 3]);
    end

    repeat (2 * MAX_ROUNDS + 8) @(posedge clk);
    $display("%0d blocks sent, %0d results checked, over %0d cipher settings",
             blocks_sent, results_checked, settings_used);
    $display("%0d register writes, including out-of-range indexes and oversized data",
             cfg_writes);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* xtea_block_cipher.f */
sv/xtea_pkg.sv
sv/xtea_round.sv
sv/xtea_block_cipher.sv
sv/xtea_chk.sv
sim/testbench.sv
